@@ rtl/mag_pkg.sv @@
package mag_pkg;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SETUP,
      ST_WDIV,
      ST_SLOTS,
      ST_CLEAR,
      ST_RDSAMP,
      ST_BDIV,
      ST_BREAD,
      ST_BWRITE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_RESULT
   } mag_state_type;

   localparam int unsigned DIFF_W  = 33;

endpackage

@@ rtl/mag_channel_if.sv @@
interface mag_req_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] value;
   logic              last_item;
   modport source (output valid, output value, output last_item, input ready);
   modport sink (input valid, input value, input last_item, output ready);
endinterface

interface mag_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] max_gap;
   logic        overflowed;
   modport source (output valid, output max_gap, output overflowed, input ready);
   modport sink (input valid, input max_gap, input overflowed, output ready);
endinterface

@@ rtl/mag_divider.sv @@
// Restoring divider, unsigned 33 / 33, one quotient bit per cycle.
module mag_divider
   import mag_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIFF_W-1:0] dividend,
   input  logic [DIFF_W-1:0] divisor,
   output logic              done,
   output logic [DIFF_W-1:0] quotient
);
   localparam int unsigned CNT_W = $clog2(DIFF_W + 1);

   logic [DIFF_W-1:0] rem_ff, rem_in;
   logic [DIFF_W-1:0] quo_ff, quo_in;
   logic [DIFF_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIFF_W:0]   trial;
   logic [DIFF_W:0]   shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[DIFF_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIFF_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIFF_W]) begin
            rem_in = trial[DIFF_W-1:0];
            quo_in = {quo_ff[DIFF_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIFF_W-1:0];
            quo_in = {quo_ff[DIFF_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

@@ rtl/maximum_adjacent_gap_unit.sv @@
// Maximum adjacent gap unit.
// req channel: one signed 32-bit value per transaction; last_item ends the set.
// rsp channel: one transaction per set carrying max_gap and overflowed.
// Loading accepts one value per cycle. After the last value the unit computes
// the gap by the bucket method: a division for the bucket width, another for
// the bucket count, a clearing sweep of all BUCKET_SLOTS entries of the
// bucket-used map (one slot a cycle), then for each stored value a division
// on the one shared restoring divider for the bucket index plus memory read
// and write, and a scan of the counted buckets, each in a read and a check state.
// A set of fewer than two values or all equal values goes straight to the result.
// The shared divider sets the time per value.
// req_ready is low from the last value until the result is registered.
// Values beyond MAX_ITEMS are dropped and reported through overflowed.
// Reset empties the set and returns to loading; no clearing pass is needed
// at reset since each set clears the bucket-used map itself.
// A stalled rsp holds the result while the next set loads; that set's result
// waits until the held one is taken.
module maximum_adjacent_gap_unit
   import mag_pkg::*;
#(
   parameter int unsigned MAX_ITEMS    = 1024,
   parameter int unsigned BUCKET_SLOTS = 2048
) (
   input  logic clock,
   input  logic reset,
   mag_req_if.sink   req,
   mag_rsp_if.source rsp
);
   localparam int unsigned AW  = $clog2(MAX_ITEMS);
   localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
   localparam int unsigned BW  = $clog2(BUCKET_SLOTS);
   localparam int unsigned SW  = $clog2(BUCKET_SLOTS + 1);

   logic signed [31:0] sample_mem [MAX_ITEMS];
   logic signed [31:0] blow_mem   [BUCKET_SLOTS];
   logic signed [31:0] bhigh_mem  [BUCKET_SLOTS];
   logic               bfill_mem  [BUCKET_SLOTS];

   mag_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic signed [31:0] min_ff, min_in, max_ff, max_in;
   logic drop_ff, drop_in;
   logic [DIFF_W-1:0] range_ff, range_in, width_ff, width_in;
   logic [SW-1:0] slots_ff, slots_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [CW-1:0] item_ff, item_in;
   logic signed [31:0] cur_ff, cur_in;
   logic [BW-1:0] bidx_ff, bidx_in;
   logic signed [31:0] prev_ff, prev_in;
   logic [DIFF_W-1:0] gap_ff, gap_in;
   logic [31:0] rsp_gap_ff, rsp_gap_in;
   logic rsp_ovf_ff, rsp_ovf_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [31:0] samp_rd_ff;
   logic signed [31:0] blow_rd_ff, bhigh_rd_ff;
   logic bfill_rd_ff;

   logic samp_we, bk_we, fill_we, fill_val;
   logic [BW-1:0] bk_waddr, bk_raddr;
   logic signed [31:0] bk_wlow, bk_whigh;
   logic [AW-1:0] samp_raddr;

   logic div_start, div_done;
   logic [DIFF_W-1:0] div_a, div_b, div_q;

   logic accept;
   logic signed [DIFF_W-1:0] diff_tmp;

   mag_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
   );

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == ST_LOAD);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.max_gap    = rsp_gap_ff;
   assign rsp.overflowed = rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (samp_we) sample_mem[count_ff[AW-1:0]] <= req.value;
      samp_rd_ff <= sample_mem[samp_raddr];
      if (bk_we) begin
         blow_mem[bk_waddr]  <= bk_wlow;
         bhigh_mem[bk_waddr] <= bk_whigh;
      end
      blow_rd_ff  <= blow_mem[bk_raddr];
      bhigh_rd_ff <= bhigh_mem[bk_raddr];
      if (fill_we) bfill_mem[bk_waddr] <= fill_val;
      bfill_rd_ff <= bfill_mem[bk_raddr];
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff; min_in = min_ff; max_in = max_ff; drop_in = drop_ff;
      range_in = range_ff; width_in = width_ff; slots_in = slots_ff;
      idx_in = idx_ff; item_in = item_ff; cur_in = cur_ff; bidx_in = bidx_ff;
      prev_in = prev_ff; gap_in = gap_ff;
      rsp_gap_in = rsp_gap_ff; rsp_ovf_in = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      samp_we = 1'b0; bk_we = 1'b0; fill_we = 1'b0; fill_val = 1'b0;
      bk_waddr = bidx_ff; bk_raddr = bidx_ff;
      bk_wlow = cur_ff; bk_whigh = cur_ff;
      samp_raddr = item_ff[AW-1:0];
      div_start = 1'b0; div_a = range_ff; div_b = width_ff;
      diff_tmp = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (count_ff < CW'(MAX_ITEMS)) begin
                  samp_we  = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (count_ff == '0 || req.value < min_ff) min_in = req.value;
                  if (count_ff == '0 || req.value > max_ff) max_in = req.value;
               end else begin
                  drop_in = 1'b1;
               end
               if (req.last_item) state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            range_in = DIFF_W'({max_ff[31], max_ff}) - DIFF_W'({min_ff[31], min_ff});
            gap_in = '0;
            if (count_ff < CW'(2) || min_ff == max_ff) begin
               state_in = ST_RESULT;
            end else begin
               div_start = 1'b1;
               div_a = DIFF_W'({max_ff[31], max_ff}) - DIFF_W'({min_ff[31], min_ff});
               div_b = DIFF_W'(count_ff - 1'b1);
               state_in = ST_WDIV;
            end
         end
         ST_WDIV: begin
            if (div_done) begin
               width_in = (div_q == '0) ? DIFF_W'(1) : div_q;
               div_start = 1'b1;
               div_a = range_ff;
               div_b = (div_q == '0) ? DIFF_W'(1) : div_q;
               state_in = ST_SLOTS;
            end
         end
         ST_SLOTS: begin
            if (div_done) begin
               if (div_q >= DIFF_W'(BUCKET_SLOTS)) slots_in = SW'(BUCKET_SLOTS);
               else slots_in = SW'(div_q + 1'b1);
               idx_in = '0;
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            fill_we = 1'b1;
            bk_waddr = idx_ff[BW-1:0];
            idx_in = idx_ff + 1'b1;
            if (idx_ff == SW'(BUCKET_SLOTS - 1)) begin
               item_in = '0;
               state_in = ST_RDSAMP;
            end
         end
         ST_RDSAMP: begin
            // read issued at item_ff; data ready next cycle
            state_in = ST_BDIV;
            idx_in = '0;
         end
         ST_BDIV: begin
            if (idx_ff == '0) begin
               cur_in = samp_rd_ff;
               div_start = 1'b1;
               div_a = DIFF_W'({samp_rd_ff[31], samp_rd_ff}) -
                       DIFF_W'({min_ff[31], min_ff});
               div_b = width_ff;
               idx_in = SW'(1);
            end else if (div_done) begin
               if (div_q >= DIFF_W'(slots_ff - 1'b1)) bidx_in = BW'(slots_ff - 1'b1);
               else bidx_in = div_q[BW-1:0];
               state_in = ST_BREAD;
               idx_in = '0;
            end
         end
         ST_BREAD: begin
            if (idx_ff == '0) idx_in = SW'(1);
            else state_in = ST_BWRITE;
         end
         ST_BWRITE: begin
            bk_we = 1'b1; fill_we = 1'b1; fill_val = 1'b1;
            if (bfill_rd_ff) begin
               bk_wlow  = (cur_ff < blow_rd_ff) ? cur_ff : blow_rd_ff;
               bk_whigh = (cur_ff > bhigh_rd_ff) ? cur_ff : bhigh_rd_ff;
            end
            item_in = item_ff + 1'b1;
            if (item_ff + 1'b1 == count_ff) begin
               idx_in = '0;
               prev_in = min_ff;
               state_in = ST_SCAN_RD;
            end else begin
               samp_raddr = item_in[AW-1:0];
               idx_in = '0;
               state_in = ST_RDSAMP;
            end
         end
         ST_SCAN_RD: begin
            bk_raddr = idx_ff[BW-1:0];
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (bfill_rd_ff) begin
               diff_tmp = DIFF_W'({blow_rd_ff[31], blow_rd_ff}) -
                          DIFF_W'({prev_ff[31], prev_ff});
               if (diff_tmp > $signed(gap_ff)) gap_in = diff_tmp;
               prev_in = bhigh_rd_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == slots_ff) state_in = ST_RESULT;
            else state_in = ST_SCAN_RD;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_gap_in = gap_ff[31:0];
               rsp_ovf_in = drop_ff;
               count_in = '0; min_in = '0; max_in = '0; drop_in = 1'b0;
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      range_ff <= range_in; width_ff <= width_in; slots_ff <= slots_in;
      idx_ff <= idx_in; item_ff <= item_in; cur_ff <= cur_in; bidx_ff <= bidx_in;
      prev_ff <= prev_in; gap_ff <= gap_in;
      rsp_gap_ff <= rsp_gap_in; rsp_ovf_ff <= rsp_ovf_in;
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0; min_ff <= '0; max_ff <= '0; drop_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in; min_ff <= min_in; max_ff <= max_in;
         drop_ff <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

@@ test/tb_maximum_adjacent_gap_unit.sv @@
`timescale 1ns / 1ps
module tb_maximum_adjacent_gap_unit;

   localparam int unsigned MAX_ITEMS    = 1024;
   localparam int unsigned WATCH_LIMIT  = 400000;

   typedef struct packed {
      logic signed [31:0] value;
      logic               last_item;
   } sample_type;

   typedef struct packed {
      logic [31:0] max_gap;
      logic        overflowed;
   } gap_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mag_req_if req ();
   mag_rsp_if rsp ();

   maximum_adjacent_gap_unit #(.MAX_ITEMS(MAX_ITEMS), .BUCKET_SLOTS(2 * MAX_ITEMS)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sample_type     pending_samples[$];
   gap_result_type expected_gaps[$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          mismatches = 0;
   int          idle_cycles = 0;
   bit          stimulus_done = 1'b0;

   // predictor state
   longint      set_values[$];
   bit          set_dropped = 1'b0;

   function automatic logic [31:0] predict_gap();
      int     n;
      longint lo, hi, range, width, slots, b, gap, prev;
      longint blo[], bhi[];
      bit     bused[];
      n = set_values.size();
      if (n < 2) return 32'd0;
      lo = set_values[0];
      hi = set_values[0];
      foreach (set_values[i]) begin
         if (set_values[i] < lo) lo = set_values[i];
         if (set_values[i] > hi) hi = set_values[i];
      end
      if (lo == hi) return 32'd0;
      range = hi - lo;
      width = range / (n - 1);
      if (width < 1) width = 1;
      slots = range / width + 1;
      if (slots > 2 * MAX_ITEMS) slots = 2 * MAX_ITEMS;
      blo = new[slots];
      bhi = new[slots];
      bused = new[slots];
      foreach (set_values[i]) begin
         b = (set_values[i] - lo) / width;
         if (b >= slots) b = slots - 1;
         if (!bused[b]) begin
            blo[b] = set_values[i];
            bhi[b] = set_values[i];
            bused[b] = 1'b1;
         end else begin
            if (set_values[i] < blo[b]) blo[b] = set_values[i];
            if (set_values[i] > bhi[b]) bhi[b] = set_values[i];
         end
      end
      gap = 0;
      prev = lo;
      for (longint i = 0; i < slots; i++) begin
         if (bused[i]) begin
            if (blo[i] - prev > gap) gap = blo[i] - prev;
            prev = bhi[i];
         end
      end
      return gap[31:0];
   endfunction

   task automatic accept_sample(input sample_type s);
      gap_result_type r;
      if (set_values.size() < MAX_ITEMS) set_values.push_back(longint'(s.value));
      else set_dropped = 1'b1;
      if (s.last_item) begin
         r.max_gap = predict_gap();
         r.overflowed = set_dropped;
         expected_gaps.push_back(r);
         set_values.delete();
         set_dropped = 1'b0;
      end
   endtask

   function automatic logic signed [31:0] pick_value(input int mode, input longint base,
                                                     input int spread);
      case (mode)
         0: return $urandom;
         1: return 32'(base + $urandom_range(spread, 0));
         2: return ($urandom_range(1, 0) != 0) ? 32'sh7fffffff - $urandom_range(3, 0)
                                              : 32'sh80000000 + $urandom_range(3, 0);
         default: return 32'(base + $urandom_range(3, 0));
      endcase
   endfunction

   task automatic add_set(input int count, input int mode);
      sample_type s;
      longint  base;
      int      spread;
      base = longint'($signed($urandom));
      spread = $urandom_range(100000, 1);
      for (int i = 0; i < count; i++) begin
         s.value = pick_value(mode, base, spread);
         s.last_item = (i == count - 1);
         pending_samples.push_back(s);
      end
   endtask

   task automatic push_one(input logic signed [31:0] v, input logic l);
      sample_type s;
      s.value = v;
      s.last_item = l;
      pending_samples.push_back(s);
   endtask

   task automatic wait_drain();
      while (pending_samples.size() != 0 || expected_gaps.size() != 0) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.value <= '0;
         req.last_item <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            accept_sample({req.value, req.last_item});
            void'(pending_samples.pop_front());
         end
         if ((req.valid && !req.ready) ) begin
            // hold
         end else if (pending_samples.size() > (req.valid && req.ready ? 0 : 0) &&
                      $urandom_range(99, 0) >= send_idle_pct) begin
            req.valid <= 1'b1;
            req.value <= pending_samples[0].value;
            req.last_item <= pending_samples[0].last_item;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_gaps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: max_gap=%0d overflowed=%0b",
                           rsp.max_gap, rsp.overflowed);
            end else begin
               if (rsp.max_gap !== expected_gaps[0].max_gap ||
                   rsp.overflowed !== expected_gaps[0].overflowed) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected gap=%0d ovf=%0b, got gap=%0d ovf=%0b",
                              expected_gaps[0].max_gap, expected_gaps[0].overflowed,
                              rsp.max_gap, rsp.overflowed);
               end
               void'(expected_gaps.pop_front());
            end
         end
         rsp.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int total;
      int n;
      int mode;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: single value, equal values, extremes, duplicates
      push_one(32'sd5, 1'b1);
      push_one(32'sd7, 1'b0);
      push_one(32'sd7, 1'b1);
      push_one(32'sh80000000, 1'b0);
      push_one(32'sh7fffffff, 1'b1);
      push_one(32'sh7fffffff, 1'b0);
      push_one(32'sh80000000, 1'b0);
      push_one(32'sd0, 1'b1);
      push_one(-32'sd1, 1'b0);
      push_one(32'sd1, 1'b0);
      push_one(32'sd1, 1'b0);
      push_one(32'sd10, 1'b1);
      push_one(32'sd3, 1'b0);
      push_one(32'sd4, 1'b0);
      push_one(32'sd5, 1'b0);
      push_one(32'sd100, 1'b1);
      push_one(32'sh55555555, 1'b0);
      push_one(32'shaaaaaaaa, 1'b1);
      wait_drain();

      // random sets fill a value budget; one overflowing set is added on top
      total = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 52 : 0;
         recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 14 : 0;
         while (total < 310 * (phase + 1)) begin
            mode = $urandom_range(3, 0);
            n = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
            add_set(n, mode);
            total += n;
         end
         if (phase == 1) add_set(MAX_ITEMS + 3, 1);
         wait_drain();
      end

      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_gaps.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
